// ===== hdl/monotone_table_segment_search_top_macros.svh =====
// Assertion macros used by the checker file of this block.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef MONOTONE_TABLE_SEGMENT_SEARCH_TOP_MACROS_SVH
`define MONOTONE_TABLE_SEGMENT_SEARCH_TOP_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define MTSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion %m failed");

// The consequent must hold in the same cycle as the antecedent.
`define MTSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion %m failed");

`endif

// ===== hdl/mtss_pkg.sv =====
`default_nettype none

package mtss_pkg;

  localparam int TableDepthDefault = 256;
  localparam int ValueWidthDefault = 32;

  localparam int LenW = 9;
  localparam int IdxW = 8;
  localparam int RawW = 32;

  // Register indexes of the configuration port.
  localparam logic CFG_SIGNED_MODE  = 1'b0;
  localparam logic CFG_TABLE_LENGTH = 1'b1;

  // Request operation codes.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef struct packed {
    logic gt;
    logic lt;
  } cmp_res_t;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/monotone_table_segment_search_top.sv =====
// Monotone table segment search.
// Requests arrive on the input channel (in_valid_i / in_ready_o). A write
// request (operation_i = 0) stores entry_value_i at entry_index_i and gives
// no result. A search request (operation_i = 1) finds the segment of the
// table that holds search_key_i and gives one result on the output channel
// (out_valid_o / out_ready_i): segment_index_o, and not_found_o when the
// table is not monotone and no segment matched.
// A search reads entry 0, entry 1 and the last entry, checks the two clamps,
// and then walks the table one entry per cycle through the single read port
// of the table memory and one shared comparator. A clamped key skips the
// walk. The input is ready again in the same cycle as the result is loaded
// into the output register. The block takes no new request while a search
// is in progress. The finished result sits in an output register; a
// stalled receiver holds back the next search's result, and the block with
// it, but write requests are still taken while no search is in progress.
// Reset empties the request path, clears the output valid, sets signed_mode
// to 0 and table_length to 2; the table content is undefined until written.
`default_nettype none

module monotone_table_segment_search_top #(
  parameter int TABLE_DEPTH = mtss_pkg::TableDepthDefault,
  parameter int VALUE_WIDTH = mtss_pkg::ValueWidthDefault
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic                      cfg_index_i,
  input  wire logic [mtss_pkg::LenW-1:0] cfg_wdata_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic                      operation_i,
  input  wire logic [mtss_pkg::IdxW-1:0] entry_index_i,
  input  wire logic [mtss_pkg::RawW-1:0] entry_value_i,
  input  wire logic [mtss_pkg::RawW-1:0] search_key_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic      [mtss_pkg::LenW-1:0] segment_index_o,
  output logic                           not_found_o
);

  import mtss_pkg::*;

  localparam int AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic                   signed_mode_q;
  logic [LenW-1:0]        table_length_q;
  logic [LenW-1:0]        length_used;

  mem_ctl_t               mem_ctl;
  logic [AddrW-1:0]       waddr;
  logic [VALUE_WIDTH-1:0] wdata;
  logic [AddrW-1:0]       raddr;
  logic [VALUE_WIDTH-1:0] rdata;
  logic [VALUE_WIDTH-1:0] cmp_a;
  logic [VALUE_WIDTH-1:0] cmp_b;
  cmp_res_t               cmp_res;

  // Configuration registers; the user must make writes only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signed_mode_q  <= 1'b0;
      table_length_q <= LenW'(2);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SIGNED_MODE:  signed_mode_q  <= cfg_wdata_i[0];
        CFG_TABLE_LENGTH: table_length_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // The length in use is held between two and the table depth.
  always_comb begin
    if (table_length_q < LenW'(2)) begin
      length_used = LenW'(2);
    end else if (32'(table_length_q) > TABLE_DEPTH) begin
      length_used = LenW'(TABLE_DEPTH);
    end else begin
      length_used = table_length_q;
    end
  end

  mtss_seq #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .entry_index_i   (entry_index_i),
    .entry_value_i   (entry_value_i[VALUE_WIDTH-1:0]),
    .search_key_i    (search_key_i[VALUE_WIDTH-1:0]),
    .length_i        (length_used),
    .mem_ctl_o       (mem_ctl),
    .waddr_o         (waddr),
    .wdata_o         (wdata),
    .raddr_o         (raddr),
    .rdata_i         (rdata),
    .cmp_a_o         (cmp_a),
    .cmp_b_o         (cmp_b),
    .cmp_i           (cmp_res),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .segment_index_o (segment_index_o),
    .not_found_o     (not_found_o)
  );

  mtss_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_ctl.we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (mem_ctl.re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  mtss_cmp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_cmp (
    .signed_mode_i (signed_mode_q),
    .a_i           (cmp_a),
    .b_i           (cmp_b),
    .res_o         (cmp_res)
  );

endmodule

`default_nettype wire

// ===== hdl/mtss_ram.sv =====
`default_nettype none

module mtss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mtss_cmp.sv =====
`default_nettype none

module mtss_cmp #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                   signed_mode_i,
  input  wire logic [VALUE_WIDTH-1:0] a_i,
  input  wire logic [VALUE_WIDTH-1:0] b_i,
  output mtss_pkg::cmp_res_t          res_o
);

  import mtss_pkg::*;

  logic [VALUE_WIDTH-1:0] flip;
  logic [VALUE_WIDTH-1:0] ka;
  logic [VALUE_WIDTH-1:0] kb;

  // Flipping the sign bit maps two's complement order onto unsigned order.
  assign flip = {signed_mode_i, {(VALUE_WIDTH-1){1'b0}}};
  assign ka = a_i ^ flip;
  assign kb = b_i ^ flip;

  assign res_o.gt = (ka > kb);
  assign res_o.lt = (ka < kb);

endmodule

`default_nettype wire

// ===== hdl/mtss_seq.sv =====
`default_nettype none

module mtss_seq #(
  parameter int TABLE_DEPTH = 256,
  parameter int VALUE_WIDTH = 32,
  localparam int AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        operation_i,
  input  wire logic [mtss_pkg::IdxW-1:0]   entry_index_i,
  input  wire logic [VALUE_WIDTH-1:0]      entry_value_i,
  input  wire logic [VALUE_WIDTH-1:0]      search_key_i,
  input  wire logic [mtss_pkg::LenW-1:0]   length_i,
  output mtss_pkg::mem_ctl_t               mem_ctl_o,
  output logic      [AddrW-1:0]            waddr_o,
  output logic      [VALUE_WIDTH-1:0]      wdata_o,
  output logic      [AddrW-1:0]            raddr_o,
  input  wire logic [VALUE_WIDTH-1:0]      rdata_i,
  output logic      [VALUE_WIDTH-1:0]      cmp_a_o,
  output logic      [VALUE_WIDTH-1:0]      cmp_b_o,
  input  mtss_pkg::cmp_res_t               cmp_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic      [mtss_pkg::LenW-1:0]   segment_index_o,
  output logic                             not_found_o
);

  import mtss_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_SECOND,
    S_LAST,
    S_CLAST,
    S_SCAN,
    S_DONE
  } state_e;

  state_e                 state_q;
  logic [VALUE_WIDTH-1:0] key_q;
  logic [VALUE_WIDTH-1:0] first_q;
  logic [VALUE_WIDTH-1:0] last_q;
  logic                   desc_q;
  logic                   prev_ok_q;
  logic [LenW-1:0]        idx_q;
  logic [LenW-1:0]        n_q;
  logic [LenW-1:0]        res_seg_q;
  logic                   res_nf_q;

  logic accept;
  logic toward_first;
  logic inside_side;
  logic beyond;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Key relative to the compared entry, in the direction of the table.
  assign toward_first = desc_q ? !cmp_i.lt : !cmp_i.gt;
  assign inside_side  = desc_q ? !cmp_i.gt : !cmp_i.lt;
  assign beyond       = !inside_side;

  always_comb begin
    mem_ctl_o = '0;
    waddr_o   = AddrW'(entry_index_i);
    wdata_o   = entry_value_i;
    raddr_o   = '0;
    cmp_a_o   = key_q;
    cmp_b_o   = rdata_i;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (operation_i == OP_WRITE) begin
            mem_ctl_o.we = (32'(entry_index_i) < TABLE_DEPTH);
          end else begin
            mem_ctl_o.re = 1'b1;
          end
        end
      end
      S_FIRST: begin
        mem_ctl_o.re = 1'b1;
        raddr_o      = AddrW'(1);
      end
      S_SECOND: begin
        cmp_a_o      = first_q;
        mem_ctl_o.re = 1'b1;
        raddr_o      = AddrW'(n_q - LenW'(1));
      end
      S_LAST: begin
        cmp_b_o = first_q;
      end
      S_CLAST: begin
        cmp_b_o      = last_q;
        mem_ctl_o.re = 1'b1;
        raddr_o      = AddrW'(1);
      end
      S_SCAN: begin
        mem_ctl_o.re = 1'b1;
        raddr_o      = AddrW'(idx_q + LenW'(1));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      key_q           <= '0;
      first_q         <= '0;
      last_q          <= '0;
      desc_q          <= 1'b0;
      prev_ok_q       <= 1'b0;
      idx_q           <= '0;
      n_q             <= '0;
      res_seg_q       <= '0;
      res_nf_q        <= 1'b0;
      out_valid_o     <= 1'b0;
      segment_index_o <= '0;
      not_found_o     <= 1'b0;
    end else begin
      // In S_DONE the valid flag is driven by the load of the output register.
      if (out_valid_o && out_ready_i && (state_q != S_DONE)) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept && (operation_i == OP_SEARCH)) begin
            key_q   <= search_key_i;
            n_q     <= length_i;
            state_q <= S_FIRST;
          end
        end
        S_FIRST: begin
          first_q <= rdata_i;
          state_q <= S_SECOND;
        end
        S_SECOND: begin
          desc_q  <= cmp_i.gt;
          state_q <= S_LAST;
        end
        S_LAST: begin
          last_q <= rdata_i;
          if (toward_first) begin
            res_seg_q <= '0;
            res_nf_q  <= 1'b0;
            state_q   <= S_DONE;
          end else begin
            state_q <= S_CLAST;
          end
        end
        S_CLAST: begin
          if (inside_side) begin
            res_seg_q <= n_q - LenW'(1);
            res_nf_q  <= 1'b0;
            state_q   <= S_DONE;
          end else begin
            // The key lies past entry 0, so segment 0 starts open.
            idx_q     <= LenW'(1);
            prev_ok_q <= 1'b1;
            state_q   <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (prev_ok_q && beyond) begin
            res_seg_q <= idx_q - LenW'(1);
            res_nf_q  <= 1'b0;
            state_q   <= S_DONE;
          end else if (idx_q == (n_q - LenW'(1))) begin
            res_seg_q <= n_q;
            res_nf_q  <= 1'b1;
            state_q   <= S_DONE;
          end else begin
            prev_ok_q <= inside_side;
            idx_q     <= idx_q + LenW'(1);
          end
        end
        S_DONE: begin
          if (!out_valid_o || out_ready_i) begin
            out_valid_o     <= 1'b1;
            segment_index_o <= res_seg_q;
            not_found_o     <= res_nf_q;
            state_q         <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mtss_checker.sv =====
`default_nettype none
`include "monotone_table_segment_search_top_macros.svh"

module mtss_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_ready_o,
  input wire logic                      operation_i,
  input wire logic                      out_valid_o,
  input wire logic                      out_ready_i,
  input wire logic [mtss_pkg::LenW-1:0] segment_index_o,
  input wire logic                      not_found_o
);

  import mtss_pkg::*;

  logic search_acc;
  logic write_acc;

  assign search_acc = in_valid_i && in_ready_o && (operation_i == OP_SEARCH);
  assign write_acc  = in_valid_i && in_ready_o && (operation_i == OP_WRITE);

  // A stalled result keeps its value.
  `MTSS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(segment_index_o) && $stable(not_found_o))

  // A search keeps the block busy in the cycle after it is taken.
  `MTSS_ASSERT_NEXT(a_search_busy, clk_i, rst_ni, search_acc, !in_ready_o)

  // A write never produces a result.
  `MTSS_ASSERT_NEXT(a_write_silent, clk_i, rst_ni, write_acc && !out_valid_o, !out_valid_o)

  // A miss reports the table length, which is at least two.
  `MTSS_ASSERT_NOW(a_miss_len, clk_i, rst_ni, out_valid_o && not_found_o,
    segment_index_o >= LenW'(2))

endmodule

bind monotone_table_segment_search_top mtss_checker u_mtss_checker (.*);

`default_nettype wire

// ===== tb/sv/monotone_table_segment_search_top_tb.sv =====
// One expected search answer: the segment and the not-found flag.
typedef struct packed {
  logic [mtss_pkg::LenW-1:0] segment;
  logic                      not_found;
} segment_result_t;

// Keeps a shadow of the table and the two registers, works out the answer of
// every accepted search and compares the block's answers against them in order.
class segment_scoreboard;
  localparam int unsigned Depth = mtss_pkg::TableDepthDefault;

  logic [mtss_pkg::RawW-1:0] entries [Depth];
  logic                      signed_mode;
  logic [mtss_pkg::LenW-1:0] length_code;
  segment_result_t           expected [$];
  int unsigned               failures;

  function new();
    signed_mode = 1'b0;
    length_code = 9'd2;
    failures    = 0;
  endfunction

  function void set_register(logic index, logic [mtss_pkg::LenW-1:0] data);
    if (index == mtss_pkg::CFG_SIGNED_MODE) begin
      signed_mode = data[0];
    end else begin
      length_code = data;
    end
  endfunction

  // Codes below two act as two, codes above the depth act as the full depth.
  function int unsigned length_in_use();
    if (length_code < 2) return 2;
    if (length_code > Depth) return Depth;
    return length_code;
  endfunction

  // Flipping the sign bit turns a two's complement order into an unsigned one.
  function logic [mtss_pkg::RawW-1:0] ordered(logic [mtss_pkg::RawW-1:0] raw);
    return signed_mode ? (raw ^ 32'h8000_0000) : raw;
  endfunction

  function segment_result_t locate_segment(logic [mtss_pkg::RawW-1:0] key_raw);
    int unsigned               n;
    logic [mtss_pkg::RawW-1:0] k, first, last, a, b;
    logic                      falling;
    segment_result_t           r;
    n       = length_in_use();
    k       = ordered(key_raw);
    first   = ordered(entries[0]);
    last    = ordered(entries[n - 1]);
    falling = first > ordered(entries[1]);
    r.segment   = 9'(n);
    r.not_found = 1'b1;
    if (falling ? (k >= first) : (k <= first)) begin
      r.segment   = '0;
      r.not_found = 1'b0;
    end else if (falling ? (k <= last) : (k >= last)) begin
      r.segment   = 9'(n - 1);
      r.not_found = 1'b0;
    end else begin
      // Lowest segment wins, so the walk stops at the first hit.
      for (int i = 0; (i + 1 < n) && r.not_found; i++) begin
        a = ordered(entries[i]);
        b = ordered(entries[i + 1]);
        if (falling ? (k <= a && k > b) : (k >= a && k < b)) begin
          r.segment   = 9'(i);
          r.not_found = 1'b0;
        end
      end
    end
    return r;
  endfunction

  function void note_request(logic op, logic [mtss_pkg::IdxW-1:0] idx,
                             logic [mtss_pkg::RawW-1:0] value,
                             logic [mtss_pkg::RawW-1:0] key);
    if (op == mtss_pkg::OP_WRITE) begin
      entries[idx] = value;
    end else begin
      expected.push_back(locate_segment(key));
    end
  endfunction

  function void check_result(logic [mtss_pkg::LenW-1:0] seg, logic nf, realtime now);
    segment_result_t want;
    if (expected.size() == 0) begin
      $display("%0.1f ns: result with no search outstanding, expected none, actual %0d/%0b",
               now, seg, nf);
      failures++;
      return;
    end
    want = expected.pop_front();
    if (seg !== want.segment) begin
      $display("%0.1f ns: segment_index mismatch, expected %0d, actual %0d",
               now, want.segment, seg);
      failures++;
    end
    if (nf !== want.not_found) begin
      $display("%0.1f ns: not_found mismatch, expected %0b, actual %0b",
               now, want.not_found, nf);
      failures++;
    end
  endfunction
endclass

module monotone_table_segment_search_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Run shape. The item target stops the random part; the cycle limit is far
  // above the slowest legal run (every item a full-length search behind a
  // stalled receiver).
  localparam int unsigned ItemTarget    = 850;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned TailCycles    = 300;
  localparam int unsigned CycleLimit    = 1_000_000;

  typedef enum logic [1:0] {
    SHAPE_RISING,
    SHAPE_FALLING,
    SHAPE_FLAT,
    SHAPE_SCRAMBLED
  } table_shape_e;

  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      cfg_we_i      = 1'b0;
  logic                      cfg_index_i   = 1'b0;
  logic [mtss_pkg::LenW-1:0] cfg_wdata_i   = '0;
  logic                      in_valid_i    = 1'b0;
  logic                      in_ready_o;
  logic                      operation_i   = 1'b0;
  logic [mtss_pkg::IdxW-1:0] entry_index_i = '0;
  logic [mtss_pkg::RawW-1:0] entry_value_i = '0;
  logic [mtss_pkg::RawW-1:0] search_key_i  = '0;
  logic                      out_valid_o;
  logic                      out_ready_i   = 1'b0;
  logic [mtss_pkg::LenW-1:0] segment_index_o;
  logic                      not_found_o;

  segment_scoreboard sb;

  // Idle rates in percent, changed by the stimulus as the run moves on.
  int unsigned send_idle_pct = 29;
  int unsigned recv_idle_pct = 52;

  // The stimulus flips the toggle to ask for a long receiver stall; the
  // receiver notices the change and counts the stall down by itself.
  bit          hold_off_toggle = 1'b0;
  bit          hold_off_seen   = 1'b0;
  int unsigned hold_off_left   = 0;

  int unsigned cycle_count = 0;

  monotone_table_segment_search_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .entry_index_i  (entry_index_i),
    .entry_value_i  (entry_value_i),
    .search_key_i   (search_key_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .segment_index_o(segment_index_o),
    .not_found_o    (not_found_o)
  );

  always #6 clk_i = ~clk_i;

  // Watchdog: a hung block or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver. Outputs are sampled right after the edge, so they still hold the
  // values that the edge itself saw; out_ready_i changes only through a
  // nonblocking assignment made here.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(segment_index_o, not_found_o, $realtime);
    end
    if (hold_off_toggle != hold_off_seen) begin
      hold_off_seen = hold_off_toggle;
      hold_off_left = HoldOffCycles;
    end
    if (hold_off_left > 0) begin
      hold_off_left = hold_off_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Offers one request and returns at the edge that accepted it. Valid stays
  // high afterwards, so back-to-back requests keep it up without a dip; it is
  // lowered only when the next call decides to idle first or results are drained.
  task automatic send_request(input logic op, input logic [mtss_pkg::IdxW-1:0] idx,
                              input logic [mtss_pkg::RawW-1:0] value,
                              input logic [mtss_pkg::RawW-1:0] key);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    entry_index_i <= idx;
    entry_value_i <= value;
    search_key_i  <= key;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_request(op, idx, value, key);
  endtask

  // Stops offering requests until every search has answered, then lets a
  // trailing write request settle before anything else happens.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes the mode register and then the length register. Only called while the block
  // is idle. The upper data bits of the mode write carry noise the block drops.
  task automatic set_mode(input logic sgn, input logic [mtss_pkg::LenW-1:0] len_code);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= mtss_pkg::CFG_SIGNED_MODE;
    cfg_wdata_i <= {8'($urandom), sgn};
    @(posedge clk_i);
    cfg_index_i <= mtss_pkg::CFG_TABLE_LENGTH;
    cfg_wdata_i <= len_code;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_register(mtss_pkg::CFG_SIGNED_MODE, {8'd0, sgn});
    sb.set_register(mtss_pkg::CFG_TABLE_LENGTH, len_code);
  endtask

  // Loads entries 0 to n-1. The values are built on the order of the active
  // mode and mapped back to raw bits, so a rising table stays rising under the
  // signed compare as well. Some tables take tiny steps so that keys one off
  // an entry land on segment borders; some repeat entries.
  task automatic load_table(input int unsigned n, input table_shape_e shape,
                            input logic sgn, input logic [mtss_pkg::RawW-1:0] ceiling);
    logic [mtss_pkg::RawW-1:0] ord [mtss_pkg::TableDepthDefault];
    logic [mtss_pkg::RawW-1:0] flip;
    logic [mtss_pkg::RawW-1:0] value;
    longint unsigned           room;
    bit                        narrow;
    flip   = sgn ? 32'h8000_0000 : 32'h0;
    narrow = ($urandom_range(0, 2) == 0);
    ord[0] = ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom_range(0, ceiling >> 2);
    for (int i = 1; i < n; i++) begin
      room = (longint'(ceiling) - ord[i - 1]) / (n - i);
      if (narrow && room > 6) room = 6;
      ord[i] = ($urandom_range(0, 7) == 0) ? ord[i - 1]
                                            : ord[i - 1] + $urandom_range(0, 32'(room));
    end
    for (int i = 0; i < n; i++) begin
      case (shape)
        SHAPE_RISING:  value = ord[i] ^ flip;
        SHAPE_FALLING: value = ord[n - 1 - i] ^ flip;
        SHAPE_FLAT:    value = ord[0] ^ flip;
        default:       value = $urandom;
      endcase
      send_request(mtss_pkg::OP_WRITE, 8'(i), value, $urandom);
    end
  endtask

  // Keys mostly sit on or right next to table entries, or halfway inside a
  // segment; the rest are the value extremes and plain noise.
  function automatic logic [mtss_pkg::RawW-1:0] pick_key(input int unsigned n);
    logic [mtss_pkg::RawW-1:0] a, b, flip;
    int unsigned               i, pick;
    flip = sb.signed_mode ? 32'h8000_0000 : 32'h0;
    i    = $urandom_range(0, n - 2);
    a    = sb.entries[i] ^ flip;
    b    = sb.entries[i + 1] ^ flip;
    pick = $urandom_range(0, 3);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return sb.entries[$urandom_range(0, n - 1)];
      4:          return sb.entries[i] + 32'd1;
      5:          return sb.entries[i] - 32'd1;
      6:          return 32'((33'(a) + 33'(b)) >> 1) ^ flip;
      7:          return (pick == 0) ? 32'h0000_0000 :
                         (pick == 1) ? 32'hFFFF_FFFF :
                         (pick == 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default:    return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned               random_items, phase, n, large_phases, searches, third, r;
    logic [mtss_pkg::LenW-1:0] len_code;
    logic                      sgn;
    bit                        late_hold_done;
    table_shape_e              shape;

    sb             = new();
    random_items   = 0;
    phase          = 0;
    large_phases   = 0;
    late_hold_done = 1'b0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. It starts on the reset settings (unsigned, two entries),
    // so the reset values of both registers get checked too.
    send_request(mtss_pkg::OP_WRITE, 8'd0, 32'h0000_0000, 32'h0);
    send_request(mtss_pkg::OP_WRITE, 8'd1, 32'hFFFF_FFFF, 32'h0);
    // Key equal to the first entry, equal to the last, and strictly between.
    send_request(mtss_pkg::OP_SEARCH, 8'd0, 32'h0, 32'h0000_0000);
    send_request(mtss_pkg::OP_SEARCH, 8'd0, 32'h0, 32'hFFFF_FFFF);
    send_request(mtss_pkg::OP_SEARCH, 8'd0, 32'h0, 32'h0000_0001);
    send_request(mtss_pkg::OP_SEARCH, 8'd0, 32'h0, 32'h8000_0000);
    // The same two entries read as signed form a falling pair (0 then -1).
    drain_results();
    set_mode(1'b1, 9'd2);
    send_request(mtss_pkg::OP_SEARCH, 8'd0, 32'h0, 32'h8000_0000);
    send_request(mtss_pkg::OP_SEARCH, 8'd0, 32'h0, 32'h7FFF_FFFF);
    send_request(mtss_pkg::OP_SEARCH, 8'd0, 32'h0, 32'h0000_0000);
    send_request(mtss_pkg::OP_SEARCH, 8'd0, 32'h0, 32'hFFFF_FFFF);
    // Three falling signed entries: 0, -1, most negative. Keys inside the open
    // lower end and on its closed upper end both fall in segment 1.
    send_request(mtss_pkg::OP_WRITE, 8'd2, 32'h8000_0000, 32'h0);
    drain_results();
    set_mode(1'b1, 9'd3);
    send_request(mtss_pkg::OP_SEARCH, 8'd0, 32'h0, 32'h8000_0001);
    send_request(mtss_pkg::OP_SEARCH, 8'd0, 32'h0, 32'hFFFF_FFFF);
    send_request(mtss_pkg::OP_SEARCH, 8'd0, 32'h0, 32'h8000_0000);
    send_request(mtss_pkg::OP_SEARCH, 8'd0, 32'h0, 32'h0000_0001);
    // Unsigned, the same entries rise and then drop: not a monotone table.
    drain_results();
    set_mode(1'b0, 9'd3);
    send_request(mtss_pkg::OP_SEARCH, 8'd0, 32'h0, 32'h7FFF_FFFF);
    send_request(mtss_pkg::OP_SEARCH, 8'd0, 32'h0, 32'h9000_0000);
    // Equal first two entries count as rising.
    send_request(mtss_pkg::OP_WRITE, 8'd1, 32'h0000_0000, 32'h0);
    send_request(mtss_pkg::OP_SEARCH, 8'd0, 32'h0, 32'h0000_0000);
    send_request(mtss_pkg::OP_SEARCH, 8'd0, 32'h0, 32'h4000_0000);

    // Random part, in phases. Each phase drains, sets both registers, loads a
    // table if short or first, then streams searches and a few stray writes.
    // The first three phases pin the length extremes: the full depth (which
    // also fills every entry, so later searches never read an unwritten one),
    // a length code above the depth, and a code below the minimum.
    while (random_items < ItemTarget) begin
      third         = random_items * 3 / ItemTarget;
      send_idle_pct = (third == 0) ? 29 : (third == 1) ? 52 : 0;
      recv_idle_pct = (third == 0) ? 52 : (third == 1) ? 29 : 0;
      sgn           = $urandom_range(0, 1);
      if (phase == 0) begin
        len_code = 9'd256;
      end else if (phase == 1) begin
        len_code = 9'd511;
      end else if (phase == 2) begin
        len_code = 9'd0;
      end else begin
        r = $urandom_range(0, 19);
        if (r < 12) begin
          len_code = 9'($urandom_range(2, 12));
        end else if (r < 16) begin
          len_code = 9'($urandom_range(13, 64));
        end else if (r == 16) begin
          len_code = 9'($urandom_range(0, 1));
        end else if (large_phases < 2) begin
          large_phases++;
          len_code = (r == 17) ? 9'd256 : 9'($urandom_range(257, 511));
        end else begin
          len_code = 9'($urandom_range(2, 8));
        end
      end

      drain_results();
      set_mode(sgn, len_code);
      n = sb.length_in_use();

      // The full table is loaded once, in the low half of the value range so
      // that it rises under both compare modes. Long tables later on keep
      // whatever the smaller phases left in them.
      if (phase == 0) begin
        load_table(n, SHAPE_RISING, sgn, 32'h7FFF_FFFF);
        random_items += n;
      end else if (n <= 64) begin
        r = $urandom_range(0, 19);
        shape = (r < 8) ? SHAPE_RISING : (r < 15) ? SHAPE_FALLING :
                (r < 17) ? SHAPE_FLAT : SHAPE_SCRAMBLED;
        load_table(n, shape, sgn, 32'hFFFF_FFFF);
        random_items += n;
      end

      // Long receiver stalls: once early and once with no idling at all. The
      // searches keep coming, so the output register fills and the block has
      // to push back on its input.
      if (phase == 3 || (third == 2 && !late_hold_done)) begin
        if (phase != 3) late_hold_done = 1'b1;
        hold_off_toggle = ~hold_off_toggle;
      end

      searches = (n > 64) ? 12 : $urandom_range(15, 35);
      repeat (searches) begin
        if ($urandom_range(0, 11) == 0) begin
          send_request(mtss_pkg::OP_WRITE, 8'($urandom), $urandom, $urandom);
        end else begin
          send_request(mtss_pkg::OP_SEARCH, 8'($urandom), $urandom, pick_key(n));
        end
        random_items++;
      end
      phase++;
    end

    // Wait for the last answers, then watch the quiet output for a while
    // longer than the slowest search.
    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (sb.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/mtss_pkg.sv
hdl/mtss_ram.sv
hdl/mtss_cmp.sv
hdl/mtss_seq.sv
hdl/monotone_table_segment_search_top.sv
hdl/mtss_checker.sv
tb/sv/monotone_table_segment_search_top_tb.sv
